// ----- sv/periodic_one_shot_timer_table_top_macros.svh -----
// Assertion macros for the periodic and one-shot timer table.
// Used by the top level; relies on clk and arst_n being in scope.
`ifndef PERIODIC_ONE_SHOT_TIMER_TABLE_TOP_MACROS_SVH
`define PERIODIC_ONE_SHOT_TIMER_TABLE_TOP_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define POTST_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// The antecedent implies the consequent at the same clock edge.
`define POTST_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ----- sv/potst_pkg.sv -----
// Shared types and constants of the periodic and one-shot timer table.
// Used by every module of the block; depends on nothing.
package potst_pkg;

	localparam int CMD_W = 3;
	localparam int ID_W = 4;
	localparam int MS_W = 32;
	localparam int STATUS_W = 2;

	localparam int S_DATA_W = 72;
	localparam int M_DATA_W = 40;
	localparam int ID_LSB = 0;
	localparam int PERIOD_LSB = 4;
	localparam int NOW_LSB = 36;

	localparam logic [CMD_W-1:0] CMD_START_PER = 3'd0;
	localparam logic [CMD_W-1:0] CMD_START_ONE = 3'd1;
	localparam logic [CMD_W-1:0] CMD_STOP = 3'd2;
	localparam logic [CMD_W-1:0] CMD_QUERY = 3'd3;
	localparam logic [CMD_W-1:0] CMD_TICK = 3'd4;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd5;

	localparam logic [STATUS_W-1:0] STAT_OK = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_UNKNOWN = 2'd2;

	localparam int FIRE_CNT_W = 5;
	localparam logic [FIRE_CNT_W-1:0] MAX_FIRES = 5'd16;

	typedef struct packed {
		logic load_elapsed;
		logic load_remain;
	} alu_ctl_t;

	typedef struct packed {
		logic wr_period;
		logic wr_last;
	} store_wr_t;

endpackage

// ----- sv/potst_store.sv -----
// Period and last-fire-time memories of the timer table.
// One write port and one registered read port; depends on potst_pkg.
module potst_store #(
	parameter int NUM_TIMERS = 16,
	parameter int TIME_BITS = 32,
	parameter int SLOT_W = 4
) (
	input  logic                 clk,
	input  potst_pkg::store_wr_t wr,
	input  logic [SLOT_W-1:0]    waddr,
	input  logic [TIME_BITS-1:0] wperiod,
	input  logic [TIME_BITS-1:0] wlast,
	input  logic [SLOT_W-1:0]    raddr,
	output logic [TIME_BITS-1:0] rperiod,
	output logic [TIME_BITS-1:0] rlast
);
	import potst_pkg::*;

	logic [TIME_BITS-1:0] period_mem [NUM_TIMERS];
	logic [TIME_BITS-1:0] last_mem [NUM_TIMERS];

	always_ff @(posedge clk) begin
		if (wr.wr_period) begin
			period_mem[waddr] <= wperiod;
		end
		if (wr.wr_last) begin
			last_mem[waddr] <= wlast;
		end
		rperiod <= period_mem[raddr];
		rlast <= last_mem[raddr];
	end

endmodule

// ----- sv/potst_alu.sv -----
// Shared subtractor of the timer table: elapsed time, then time remaining.
// One subtraction per step, result registered; depends on potst_pkg.
module potst_alu #(
	parameter int TIME_BITS = 32
) (
	input  logic                 clk,
	input  potst_pkg::alu_ctl_t  ctl,
	input  logic [TIME_BITS-1:0] now,
	input  logic [TIME_BITS-1:0] last,
	input  logic [TIME_BITS-1:0] period,
	output logic                 overdue,
	output logic [TIME_BITS-1:0] remain
);
	import potst_pkg::*;

	logic [TIME_BITS:0] sub_q;
	logic [TIME_BITS:0] opa;
	logic [TIME_BITS:0] opb;
	logic [TIME_BITS:0] diff;

	assign opa = ctl.load_remain ? {1'b0, period} : {1'b0, now};
	assign opb = ctl.load_remain ? {1'b0, sub_q[TIME_BITS-1:0]} : {1'b0, last};
	assign diff = opa - opb;

	always_ff @(posedge clk) begin
		if (ctl.load_elapsed) begin
			sub_q <= {1'b0, diff[TIME_BITS-1:0]};
		end else if (ctl.load_remain) begin
			sub_q <= diff;
		end
	end

	// A borrow or a zero difference means the elapsed time reached the period.
	assign overdue = sub_q[TIME_BITS] | (sub_q[TIME_BITS-1:0] == '0);
	assign remain = sub_q[TIME_BITS-1:0];

endmodule

// ----- sv/periodic_one_shot_timer_table_top.sv -----
// Top level of the periodic and one-shot timer table: sequencer and output register.
// Instantiates potst_store and potst_alu; depends on potst_pkg and the macros header.
//
// Channel  Dir  tdata (low bit up)                               tuser     tlast
// s_*      in   timer_id[3:0] period_ms[35:4] now_ms[67:36]      cmd[2:0]  -
// m_*      out  status[1:0] result_id[5:2] is_running[6]        fired     last
//               remaining_ms[38:7]
//
// Start, stop, clear all and unknown ids go straight to the reply, then wait for the output.
// A query of a running timer steps through memory read, two subtractions and reply.
// A tick scans the slots in use, reading and subtracting for each running one; a fire waits for the output.
// The block takes one beat at a time; s_tready is high only while it waits for a command.
// Reset clears the slot count and all running marks at once; there is no clearing pass.
`include "periodic_one_shot_timer_table_top_macros.svh"

module periodic_one_shot_timer_table_top #(
	parameter int NUM_TIMERS = 16,
	parameter int TIME_BITS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [potst_pkg::S_DATA_W-1:0] s_tdata,  // timer_id, period_ms, now_ms
	input  logic [potst_pkg::CMD_W-1:0]    s_tuser,  // cmd
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [potst_pkg::M_DATA_W-1:0] m_tdata,  // status, result_id, is_running,
	                                                 // remaining_ms
	output logic                           m_tuser,  // fired
	output logic                           m_tlast   // last
);
	import potst_pkg::*;

	localparam int CNT_W = $clog2(NUM_TIMERS + 1);
	localparam int SLOT_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_RD = 3'd2;
	localparam logic [2:0] ST_SUB1 = 3'd3;
	localparam logic [2:0] ST_SUB2 = 3'd4;
	localparam logic [2:0] ST_EVAL = 3'd5;
	localparam logic [2:0] ST_REPLY = 3'd6;

	logic [2:0] state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] idx_q;
	logic [FIRE_CNT_W-1:0] fire_cnt_q;
	logic [NUM_TIMERS-1:0] running_q;
	logic [NUM_TIMERS-1:0] periodic_q;
	logic [CMD_W-1:0] cmd_q;
	logic [TIME_BITS-1:0] now_q;
	logic pend_v_q;
	logic [ID_W-1:0] pend_id_q;

	logic [STATUS_W-1:0] rep_status_q;
	logic [ID_W-1:0] rep_id_q;
	logic rep_run_q;
	logic [MS_W-1:0] rep_rem_q;
	logic rep_fired_q;

	logic m_valid_q;
	logic [STATUS_W-1:0] m_status_q;
	logic [ID_W-1:0] m_id_q;
	logic m_run_q;
	logic [MS_W-1:0] m_rem_q;
	logic m_fired_q;
	logic m_last_q;

	logic [ID_W-1:0] s_id;
	logic [MS_W-1:0] s_period;
	logic [MS_W-1:0] s_now;
	logic [TIME_BITS+MS_W-1:0] period_ext;
	logic [TIME_BITS+MS_W-1:0] now_ext;
	logic [TIME_BITS-1:0] s_period_t;
	logic [TIME_BITS-1:0] s_now_t;
	logic [CNT_W+ID_W-1:0] id_cmp;
	logic [CNT_W+ID_W-1:0] cnt_cmp;
	logic [SLOT_W+ID_W-1:0] id_ext;
	logic [SLOT_W+ID_W-1:0] cnt_ext;
	logic [SLOT_W+ID_W-1:0] idx_ext;
	logic [SLOT_W-1:0] id_slot;
	logic [SLOT_W-1:0] cnt_slot;
	logic [SLOT_W-1:0] idx_slot;
	logic [ID_W-1:0] cnt_id;
	logic [ID_W-1:0] idx_id;

	logic s_acc;
	logic full;
	logic id_known;
	logic is_start;
	logic start_wr;
	logic out_free;
	logic fire_go;
	logic out_load;
	logic scan_more;

	alu_ctl_t alu_ctl;
	store_wr_t st_wr;
	logic [SLOT_W-1:0] st_waddr;
	logic [TIME_BITS-1:0] st_wlast;
	logic [TIME_BITS-1:0] rd_period;
	logic [TIME_BITS-1:0] rd_last;
	logic alu_overdue;
	logic [TIME_BITS-1:0] alu_remain;
	logic [TIME_BITS+MS_W-1:0] remain_ext;
	logic [MS_W-1:0] remain_ms;

	logic [STATUS_W-1:0] o_status;
	logic [ID_W-1:0] o_id;
	logic o_run;
	logic [MS_W-1:0] o_rem;
	logic o_fired;
	logic o_last;

	assign s_id = s_tdata[ID_LSB +: ID_W];
	assign s_period = s_tdata[PERIOD_LSB +: MS_W];
	assign s_now = s_tdata[NOW_LSB +: MS_W];
	assign period_ext = {{TIME_BITS{1'b0}}, s_period};
	assign now_ext = {{TIME_BITS{1'b0}}, s_now};
	assign s_period_t = period_ext[TIME_BITS-1:0];
	assign s_now_t = now_ext[TIME_BITS-1:0];

	assign id_cmp = {{CNT_W{1'b0}}, s_id};
	assign cnt_cmp = {{ID_W{1'b0}}, cnt_q};
	assign id_ext = {{SLOT_W{1'b0}}, s_id};
	assign id_slot = id_ext[SLOT_W-1:0];
	assign cnt_slot = cnt_q[SLOT_W-1:0];
	assign idx_slot = idx_q[SLOT_W-1:0];
	assign cnt_ext = {{ID_W{1'b0}}, cnt_slot};
	assign idx_ext = {{ID_W{1'b0}}, idx_slot};
	assign cnt_id = cnt_ext[ID_W-1:0];
	assign idx_id = idx_ext[ID_W-1:0];

	assign s_tready = (state_q == ST_IDLE);
	assign s_acc = s_tvalid & s_tready;
	assign full = (cnt_q == CNT_W'(NUM_TIMERS));
	assign id_known = (id_cmp < cnt_cmp);
	assign is_start = (s_tuser == CMD_START_PER) || (s_tuser == CMD_START_ONE);
	assign start_wr = s_acc & is_start & ~full;
	assign out_free = ~m_valid_q | m_tready;
	assign scan_more = (idx_q < cnt_q) && (fire_cnt_q < MAX_FIRES);

	assign fire_go = (state_q == ST_EVAL) && (cmd_q == CMD_TICK) && alu_overdue
		&& (!pend_v_q || out_free);
	assign out_load = ((state_q == ST_REPLY) && out_free) || (fire_go && pend_v_q);

	assign alu_ctl.load_elapsed = (state_q == ST_SUB1);
	assign alu_ctl.load_remain = (state_q == ST_SUB2);

	assign st_wr.wr_period = start_wr;
	assign st_wr.wr_last = start_wr | fire_go;
	assign st_waddr = (state_q == ST_IDLE) ? cnt_slot : idx_slot;
	assign st_wlast = (state_q == ST_IDLE) ? s_now_t : now_q;

	potst_store #(
		.NUM_TIMERS(NUM_TIMERS),
		.TIME_BITS(TIME_BITS),
		.SLOT_W(SLOT_W)
	) u_store (
		.clk(clk),
		.wr(st_wr),
		.waddr(st_waddr),
		.wperiod(s_period_t),
		.wlast(st_wlast),
		.raddr(idx_slot),
		.rperiod(rd_period),
		.rlast(rd_last)
	);

	potst_alu #(
		.TIME_BITS(TIME_BITS)
	) u_alu (
		.clk(clk),
		.ctl(alu_ctl),
		.now(now_q),
		.last(rd_last),
		.period(rd_period),
		.overdue(alu_overdue),
		.remain(alu_remain)
	);

	assign remain_ext = {{MS_W{1'b0}}, alu_remain};
	assign remain_ms = remain_ext[MS_W-1:0];

	always_comb begin
		if (state_q == ST_REPLY) begin
			o_status = rep_status_q;
			o_id = rep_id_q;
			o_run = rep_run_q;
			o_rem = rep_rem_q;
			o_fired = rep_fired_q;
			o_last = 1'b1;
		end else begin
			o_status = STAT_OK;
			o_id = pend_id_q;
			o_run = 1'b0;
			o_rem = '0;
			o_fired = 1'b1;
			o_last = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start_wr) begin
			periodic_q[cnt_slot] <= (s_tuser == CMD_START_PER);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			idx_q <= '0;
			fire_cnt_q <= '0;
			running_q <= '0;
			pend_v_q <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				m_valid_q <= 1'b1;
				m_status_q <= o_status;
				m_id_q <= o_id;
				m_run_q <= o_run;
				m_rem_q <= o_rem;
				m_fired_q <= o_fired;
				m_last_q <= o_last;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						cmd_q <= s_tuser;
						now_q <= s_now_t;
						rep_run_q <= 1'b0;
						rep_rem_q <= '0;
						rep_fired_q <= 1'b0;
						case (s_tuser)
							CMD_START_PER, CMD_START_ONE: begin
								rep_status_q <= full ? STAT_FULL : STAT_OK;
								rep_id_q <= full ? {ID_W{1'b0}} : cnt_id;
								if (!full) begin
									running_q[cnt_slot] <= 1'b1;
									cnt_q <= cnt_q + CNT_W'(1);
								end
								state_q <= ST_REPLY;
							end
							CMD_STOP: begin
								rep_id_q <= s_id;
								rep_status_q <= id_known ? STAT_OK : STAT_UNKNOWN;
								if (id_known) begin
									running_q[id_slot] <= 1'b0;
								end
								state_q <= ST_REPLY;
							end
							CMD_QUERY: begin
								rep_id_q <= s_id;
								rep_status_q <= id_known ? STAT_OK : STAT_UNKNOWN;
								if (id_known && running_q[id_slot]) begin
									idx_q <= {{(CNT_W-SLOT_W){1'b0}}, id_slot};
									state_q <= ST_RD;
								end else begin
									state_q <= ST_REPLY;
								end
							end
							CMD_TICK: begin
								rep_status_q <= STAT_OK;
								rep_id_q <= '0;
								idx_q <= '0;
								fire_cnt_q <= '0;
								pend_v_q <= 1'b0;
								state_q <= ST_SCAN;
							end
							CMD_CLEAR: begin
								rep_status_q <= STAT_OK;
								rep_id_q <= '0;
								cnt_q <= '0;
								running_q <= '0;
								state_q <= ST_REPLY;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (scan_more) begin
						if (running_q[idx_slot]) begin
							state_q <= ST_RD;
						end else begin
							idx_q <= idx_q + CNT_W'(1);
						end
					end else begin
						rep_status_q <= STAT_OK;
						rep_run_q <= 1'b0;
						rep_rem_q <= '0;
						rep_id_q <= pend_v_q ? pend_id_q : '0;
						rep_fired_q <= pend_v_q;
						pend_v_q <= 1'b0;
						state_q <= ST_REPLY;
					end
				end
				ST_RD: begin
					state_q <= ST_SUB1;
				end
				ST_SUB1: begin
					state_q <= ST_SUB2;
				end
				ST_SUB2: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (cmd_q == CMD_QUERY) begin
						rep_status_q <= STAT_OK;
						rep_id_q <= idx_id;
						rep_run_q <= 1'b1;
						rep_rem_q <= alu_overdue ? '0 : remain_ms;
						rep_fired_q <= 1'b0;
						state_q <= ST_REPLY;
					end else if (!alu_overdue) begin
						idx_q <= idx_q + CNT_W'(1);
						state_q <= ST_SCAN;
					end else if (fire_go) begin
						if (!periodic_q[idx_slot]) begin
							running_q[idx_slot] <= 1'b0;
						end
						pend_v_q <= 1'b1;
						pend_id_q <= idx_id;
						fire_cnt_q <= fire_cnt_q + FIRE_CNT_W'(1);
						idx_q <= idx_q + CNT_W'(1);
						state_q <= ST_SCAN;
					end
				end
				ST_REPLY: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = {1'b0, m_rem_q, m_run_q, m_id_q, m_status_q};
	assign m_tuser = m_fired_q;
	assign m_tlast = m_last_q;

	`POTST_ASSERT_ALWAYS(a_cnt_range, cnt_q <= CNT_W'(NUM_TIMERS), "slot count beyond table size")
	`POTST_ASSERT_ALWAYS(a_fire_cap, fire_cnt_q <= MAX_FIRES, "tick fired more than the cap")
	`POTST_ASSERT_IMPLY(a_idle_no_pend, state_q == ST_IDLE, !pend_v_q, "fire left pending at idle")
	`POTST_ASSERT_IMPLY(a_fire_beat, m_valid_q && m_fired_q,
		m_status_q == STAT_OK && !m_run_q && m_rem_q == '0, "fire beat carries query data")

endmodule
